// ----- design/baro_pressure_temp_compensation_top_assert.svh -----
// Assertion macros for the compensation pipeline. Every macro samples on the
// rising edge of clk and is disabled while rst_n is low.
`ifndef BARO_PRESSURE_TEMP_COMPENSATION_TOP_ASSERT_SVH
`define BARO_PRESSURE_TEMP_COMPENSATION_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BPTC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BPTC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/bptc_pkg.sv -----
`timescale 1ns / 1ps

package bptc_pkg;

    // Number of register stages from the input beat to the result register.
    localparam int STAGES = 10;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_SENS_BASE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OFF_BASE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SENS_TEMPCO = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OFF_TEMPCO  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REF_TEMP    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TEMP_SENS   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SO_ENABLE   = 3'd6;

    // Reference temperature of 20.00 C and the distance from it to -15.00 C.
    localparam logic signed [19:0] TEMP_BASE = 20'sd2000;
    localparam logic signed [19:0] COLD_SPAN = 20'sd3500;
    localparam logic signed [18:0] COLD_LO   = -19'sd3500;

    typedef struct packed {
        logic [23:0] raw_pressure;
        logic [23:0] raw_temperature;
    } sample_t;

    typedef struct packed {
        logic signed [31:0] temperature;
        logic signed [31:0] pressure;
    } result_t;

    typedef struct packed {
        logic [15:0] sens_base;
        logic [15:0] off_base;
        logic [15:0] sens_tempco;
        logic [15:0] off_tempco;
        logic [15:0] ref_temp;
        logic [15:0] temp_sens;
        logic        second_order_enable;
    } coef_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647)
        begin
            r = 32'sh7FFF_FFFF;
        end
        else if (v < -64'sd2147483648)
        begin
            r = 32'sh8000_0000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// ----- design/baro_pressure_temp_compensation_top.sv -----
// Barometric pressure and temperature compensation. Each input beat carries one
// raw 24-bit pressure conversion and one raw 24-bit temperature conversion; each
// result beat carries the compensated temperature (hundredths of a degree C) and
// pressure (hundredths of a millibar), both signed 32-bit and saturated. The six
// calibration coefficients and the second-order enable sit in a write-only
// register file at indices 0 through 6; writes to index 7 are ignored, and the
// registers should be changed only while no beat is in flight. The datapath is a
// ten-stage pipeline that takes a new sample pair in every cycle while sample_stall
// is low; the result beat sits in the stage-ten output register and is taken
// whenever the output is not stalled. The depth is
// set by the chain of dependent multiplies: the temperature delta, its products
// with the coefficients, the squares for the low-temperature correction, and the
// 24 by 40 bit pressure product, which is split into two partial products in one
// stage and summed in the next. A stall on the result side freezes only the full
// stages; empty stages keep filling, so sample_stall rises only once every stage
// holds a beat. There is no clearing pass after reset.
`timescale 1ns / 1ps
`include "baro_pressure_temp_compensation_top_assert.svh"

module baro_pressure_temp_compensation_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                sample_valid,
    output logic                                sample_stall,
    input  bptc_pkg::sample_t                   sample,
    output logic                                result_valid,
    input  logic                                result_stall,
    output bptc_pkg::result_t                   result,
    input  logic                                cfg_we,
    input  logic [bptc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bptc_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import bptc_pkg::*;

    coef_t coef;

    // Per-stage valid bits and the load enables derived from them.
    logic [STAGES:1] vld_reg;
    logic [STAGES:1] vld_next;
    logic [STAGES:1] rdy;
    logic [STAGES:1] vld_src;

    // Stage 1: temperature delta.
    logic [23:0]        d1_s1_reg;
    logic signed [24:0] dt_reg;
    logic signed [24:0] dt_next;

    // Stage 2: products of the delta, kept already shifted.
    logic [23:0]        d1_s2_reg;
    logic signed [41:0] pt_w;
    logic signed [41:0] poff_w;
    logic signed [41:0] psens_w;
    logic signed [49:0] pdd_w;
    logic signed [18:0] lo_reg;
    logic signed [18:0] lo_next;
    logic signed [34:0] offt_reg;
    logic signed [34:0] offt_next;
    logic signed [33:0] senst_reg;
    logic signed [33:0] senst_next;
    logic [17:0]        t2_s2_reg;
    logic [17:0]        t2_s2_next;

    // Stage 3: first-order results and the low-temperature square.
    logic [23:0]        d1_s3_reg;
    logic signed [19:0] temp_s3_reg;
    logic signed [19:0] temp_s3_next;
    logic signed [39:0] off_s3_reg;
    logic signed [39:0] off_s3_next;
    logic signed [39:0] sens_s3_reg;
    logic signed [39:0] sens_s3_next;
    logic [17:0]        t2_s3_reg;
    logic               corr_s3_reg;
    logic               corr_s3_next;
    logic               cold_s3_reg;
    logic               cold_s3_next;
    logic signed [37:0] losq_w;
    logic [35:0]        losq_reg;
    logic [35:0]        losq_next;
    logic signed [19:0] vl_reg;
    logic signed [19:0] vl_next;

    // Stage 4: scaled square and the very-low-temperature square.
    logic [23:0]        d1_s4_reg;
    logic signed [19:0] temp_s4_reg;
    logic signed [39:0] off_s4_reg;
    logic signed [39:0] sens_s4_reg;
    logic [17:0]        t2_s4_reg;
    logic               corr_s4_reg;
    logic               cold_s4_reg;
    logic [39:0]        losq5_w;
    logic [39:0]        off2a_reg;
    logic [39:0]        off2a_next;
    logic [39:0]        sens2a_reg;
    logic [39:0]        sens2a_next;
    logic signed [39:0] vlsq_w;
    logic [35:0]        vlsq_reg;
    logic [35:0]        vlsq_next;

    // Stage 5: complete correction terms, corrected temperature.
    logic [23:0]        d1_s5_reg;
    logic signed [19:0] temp_s5_reg;
    logic signed [19:0] temp_s5_next;
    logic signed [39:0] off_s5_reg;
    logic signed [39:0] sens_s5_reg;
    logic               corr_s5_reg;
    logic [39:0]        v7_w;
    logic [39:0]        v11_w;
    logic [39:0]        off2_reg;
    logic [39:0]        off2_next;
    logic [39:0]        sens2_reg;
    logic [39:0]        sens2_next;

    // Stage 6: corrected offset and sensitivity.
    logic [23:0]        d1_s6_reg;
    logic signed [19:0] temp_s6_reg;
    logic signed [39:0] off_s6_reg;
    logic signed [39:0] off_s6_next;
    logic signed [39:0] sens_s6_reg;
    logic signed [39:0] sens_s6_next;

    // Stage 7: partial products of raw pressure and sensitivity.
    logic signed [19:0] temp_s7_reg;
    logic signed [39:0] off_s7_reg;
    logic [43:0]        pl_reg;
    logic [43:0]        pl_next;
    logic signed [44:0] ph_w;
    logic [43:0]        ph_reg;
    logic [43:0]        ph_next;

    // Stage 8: full product.
    logic signed [19:0] temp_s8_reg;
    logic signed [39:0] off_s8_reg;
    logic signed [63:0] prod_reg;
    logic signed [63:0] prod_next;

    // Stage 9: scaled product minus offset.
    logic signed [19:0] temp_s9_reg;
    logic signed [42:0] q_w;
    logic signed [43:0] x_reg;
    logic signed [43:0] x_next;

    // Stage 10: output register.
    result_t            result_reg;
    result_t            result_next;
    logic signed [28:0] pres_w;

    bptc_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .coef      (coef)
    );

    // A stage loads when it is empty or when the stage after it loads, so bubbles
    // close up behind a stalled result.
    always_comb
    begin
        rdy[STAGES] = !vld_reg[STAGES] || !result_stall;
        for (int i = STAGES - 1; i >= 1; i--)
        begin
            rdy[i] = !vld_reg[i] || rdy[i + 1];
        end
    end

    assign vld_src  = {vld_reg[STAGES-1:1], sample_valid};
    assign vld_next = (rdy & vld_src) | (~rdy & vld_reg);

    assign sample_stall = !rdy[1];
    assign result_valid = vld_reg[STAGES];
    assign result       = result_reg;

    // Stage 1: dT = D2 - C5 * 256.
    assign dt_next = $signed({1'b0, sample.raw_temperature})
                   - $signed({1'b0, coef.ref_temp, 8'b0});

    // Stage 2: the arithmetic right shifts are taken as slices of the products.
    assign pt_w    = dt_reg * $signed({1'b0, coef.temp_sens});
    assign poff_w  = dt_reg * $signed({1'b0, coef.off_tempco});
    assign psens_w = dt_reg * $signed({1'b0, coef.sens_tempco});
    assign pdd_w   = dt_reg * dt_reg;

    assign lo_next    = pt_w[41:23];
    assign offt_next  = poff_w[41:7];
    assign senst_next = psens_w[41:8];
    assign t2_s2_next = pdd_w[48:31];

    // Stage 3: lo_reg is TEMP - 2000, so it is negative exactly when the
    // temperature is below 20.00 C, and below -3500 when under -15.00 C.
    assign temp_s3_next = {lo_reg[18], lo_reg} + TEMP_BASE;
    assign off_s3_next  = {{5{offt_reg[34]}}, offt_reg} + {8'b0, coef.off_base, 16'b0};
    assign sens_s3_next = {{6{senst_reg[33]}}, senst_reg} + {9'b0, coef.sens_base, 15'b0};
    assign corr_s3_next = coef.second_order_enable && lo_reg[18];
    assign cold_s3_next = lo_reg < COLD_LO;
    assign losq_w       = lo_reg * lo_reg;
    assign losq_next    = losq_w[35:0];
    assign vl_next      = {lo_reg[18], lo_reg} + COLD_SPAN;

    // Stage 4: 5 * lo^2 halved and quartered; the values are non-negative.
    assign losq5_w     = {2'b0, losq_reg, 2'b0} + {4'b0, losq_reg};
    assign off2a_next  = {1'b0, losq5_w[39:1]};
    assign sens2a_next = {2'b0, losq5_w[39:2]};
    assign vlsq_w      = vl_reg * vl_reg;
    assign vlsq_next   = vlsq_w[35:0];

    // Stage 5: add the very-low-temperature terms and correct the temperature.
    assign v7_w  = {1'b0, vlsq_reg, 3'b0} - {4'b0, vlsq_reg};
    assign v11_w = {1'b0, vlsq_reg, 3'b0} + {3'b0, vlsq_reg, 1'b0} + {4'b0, vlsq_reg};

    assign off2_next    = off2a_reg + (cold_s4_reg ? v7_w : 40'd0);
    assign sens2_next   = sens2a_reg + (cold_s4_reg ? {1'b0, v11_w[39:1]} : 40'd0);
    assign temp_s5_next = corr_s4_reg ? (temp_s4_reg - $signed({2'b0, t2_s4_reg}))
                                      : temp_s4_reg;

    // Stage 6: apply the correction to offset and sensitivity.
    assign off_s6_next  = corr_s5_reg ? (off_s5_reg - $signed(off2_reg)) : off_s5_reg;
    assign sens_s6_next = corr_s5_reg ? (sens_s5_reg - $signed(sens2_reg)) : sens_s5_reg;

    // Stage 7: D1 * SENS split at bit 20 of the sensitivity.
    assign pl_next = d1_s6_reg * sens_s6_reg[19:0];
    assign ph_w    = $signed({1'b0, d1_s6_reg}) * $signed(sens_s6_reg[39:20]);
    assign ph_next = ph_w[43:0];

    // Stage 8: recombine; the product always fits in 64 signed bits.
    assign prod_next = $signed({ph_reg, 20'b0} + {20'b0, pl_reg});

    // Stage 9: (D1 * SENS) >> 21 - OFF.
    assign q_w    = prod_reg[63:21];
    assign x_next = {q_w[42], q_w} - {{4{off_s8_reg[39]}}, off_s8_reg};

    // Stage 10: final shift by 15 and saturation.
    assign pres_w = x_reg[43:15];

    always_comb
    begin
        result_next.temperature = sat32({{44{temp_s9_reg[19]}}, temp_s9_reg});
        result_next.pressure    = sat32({{35{pres_w[28]}}, pres_w});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[1])
        begin
            d1_s1_reg <= sample.raw_pressure;
            dt_reg    <= dt_next;
        end
        if (rdy[2])
        begin
            d1_s2_reg <= d1_s1_reg;
            lo_reg    <= lo_next;
            offt_reg  <= offt_next;
            senst_reg <= senst_next;
            t2_s2_reg <= t2_s2_next;
        end
        if (rdy[3])
        begin
            d1_s3_reg   <= d1_s2_reg;
            temp_s3_reg <= temp_s3_next;
            off_s3_reg  <= off_s3_next;
            sens_s3_reg <= sens_s3_next;
            t2_s3_reg   <= t2_s2_reg;
            corr_s3_reg <= corr_s3_next;
            cold_s3_reg <= cold_s3_next;
            losq_reg    <= losq_next;
            vl_reg      <= vl_next;
        end
        if (rdy[4])
        begin
            d1_s4_reg   <= d1_s3_reg;
            temp_s4_reg <= temp_s3_reg;
            off_s4_reg  <= off_s3_reg;
            sens_s4_reg <= sens_s3_reg;
            t2_s4_reg   <= t2_s3_reg;
            corr_s4_reg <= corr_s3_reg;
            cold_s4_reg <= cold_s3_reg;
            off2a_reg   <= off2a_next;
            sens2a_reg  <= sens2a_next;
            vlsq_reg    <= vlsq_next;
        end
        if (rdy[5])
        begin
            d1_s5_reg   <= d1_s4_reg;
            temp_s5_reg <= temp_s5_next;
            off_s5_reg  <= off_s4_reg;
            sens_s5_reg <= sens_s4_reg;
            corr_s5_reg <= corr_s4_reg;
            off2_reg    <= off2_next;
            sens2_reg   <= sens2_next;
        end
        if (rdy[6])
        begin
            d1_s6_reg   <= d1_s5_reg;
            temp_s6_reg <= temp_s5_reg;
            off_s6_reg  <= off_s6_next;
            sens_s6_reg <= sens_s6_next;
        end
        if (rdy[7])
        begin
            temp_s7_reg <= temp_s6_reg;
            off_s7_reg  <= off_s6_reg;
            pl_reg      <= pl_next;
            ph_reg      <= ph_next;
        end
        if (rdy[8])
        begin
            temp_s8_reg <= temp_s7_reg;
            off_s8_reg  <= off_s7_reg;
            prod_reg    <= prod_next;
        end
        if (rdy[9])
        begin
            temp_s9_reg <= temp_s8_reg;
            x_reg       <= x_next;
        end
        if (rdy[10])
        begin
            result_reg <= result_next;
        end
    end

    // The input side is held off only when every stage holds a beat.
    `BPTC_ASSERT_SAME(a_stall_only_when_full, sample_stall, &vld_reg, "input stalled with a free stage")
    // An accepted beat always lands in the first stage.
    `BPTC_ASSERT_NEXT(a_accept_lands, sample_valid && !sample_stall, vld_reg[1], "accepted beat was lost")
    // The low-temperature correction is only flagged below the reference temperature.
    `BPTC_ASSERT_SAME(a_corr_below_ref, vld_reg[3] && corr_s3_reg, temp_s3_reg < TEMP_BASE, "correction flagged at or above reference")

endmodule

// ----- design/bptc_cfg_regs.sv -----
`timescale 1ns / 1ps

module bptc_cfg_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [bptc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bptc_pkg::CFG_DATA_W-1:0]     cfg_data,
    output bptc_pkg::coef_t                     coef
);
    import bptc_pkg::*;

    coef_t coef_reg;
    coef_t coef_next;

    // Writes to an index past the last register are dropped.
    always_comb
    begin
        coef_next = coef_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_SENS_BASE:   coef_next.sens_base           = cfg_data;
                REG_OFF_BASE:    coef_next.off_base            = cfg_data;
                REG_SENS_TEMPCO: coef_next.sens_tempco         = cfg_data;
                REG_OFF_TEMPCO:  coef_next.off_tempco          = cfg_data;
                REG_REF_TEMP:    coef_next.ref_temp            = cfg_data;
                REG_TEMP_SENS:   coef_next.temp_sens           = cfg_data;
                REG_SO_ENABLE:   coef_next.second_order_enable = cfg_data[0];
                default:         coef_next = coef_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg <= '0;
        end
        else
        begin
            coef_reg <= coef_next;
        end
    end

    assign coef = coef_reg;

endmodule

// ----- tb/sv/baro_pressure_temp_compensation_top_tb.sv -----
`timescale 1ns / 1ps

module baro_pressure_temp_compensation_top_tb;
    import bptc_pkg::*;

    // The run is stopped by the watchdog long after the slowest correct run would end.
    localparam int CYCLE_LIMIT     = 400000;
    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 118;
    // Length of the one long hold-off on the result side, in clock cycles.
    localparam int LONG_HOLD       = 60;

    // Index 7 is not mapped to any register; writes there must be dropped.
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;
    localparam logic [23:0] RAW_MAX  = 24'hFF_FFFF;
    localparam logic [15:0] COEF_MAX = 16'hFFFF;

    // Holds the calibration registers as the block should see them and predicts
    // the compensated result for every sample beat that the block accepts.
    class compensation_scoreboard;
        coef_t   coefs;
        result_t expected_results[$];
        int      errors;

        function new();
            coefs  = '0;
            errors = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] index,
                                   logic [CFG_DATA_W-1:0] data);
            case (index)
                REG_SENS_BASE:   coefs.sens_base = data;
                REG_OFF_BASE:    coefs.off_base = data;
                REG_SENS_TEMPCO: coefs.sens_tempco = data;
                REG_OFF_TEMPCO:  coefs.off_tempco = data;
                REG_REF_TEMP:    coefs.ref_temp = data;
                REG_TEMP_SENS:   coefs.temp_sens = data;
                REG_SO_ENABLE:   coefs.second_order_enable = data[0];
                default:         ;
            endcase
        endfunction

        function logic signed [31:0] clamp_to_int32(longint v);
            if (v > 64'sd2147483647) begin
                return 32'sh7FFF_FFFF;
            end
            if (v < -64'sd2147483648) begin
                return 32'sh8000_0000;
            end
            return v[31:0];
        endfunction

        // All terms are 64-bit signed; >>> on a signed longint floors, and the
        // divisions below only ever see non-negative values.
        function result_t compensate(sample_t s);
            longint d1, d2, c1, c2, c3, c4, c5, c6;
            longint dt, temp, off, sens, pres, t2, lo, vl, off2, sens2;
            result_t r;
            d1 = s.raw_pressure;
            d2 = s.raw_temperature;
            c1 = coefs.sens_base;
            c2 = coefs.off_base;
            c3 = coefs.sens_tempco;
            c4 = coefs.off_tempco;
            c5 = coefs.ref_temp;
            c6 = coefs.temp_sens;

            dt   = d2 - c5 * 256;
            temp = 2000 + ((dt * c6) >>> 23);
            off  = c2 * 65536 + ((c4 * dt) >>> 7);
            sens = c1 * 32768 + ((c3 * dt) >>> 8);

            if (coefs.second_order_enable && temp < 2000) begin
                t2    = (dt * dt) >>> 31;
                lo    = temp - 2000;
                off2  = (5 * lo * lo) / 2;
                sens2 = (5 * lo * lo) / 4;
                if (temp < -1500) begin
                    vl    = temp + 1500;
                    off2  = off2 + 7 * vl * vl;
                    sens2 = sens2 + (11 * vl * vl) / 2;
                end
                temp = temp - t2;
                off  = off - off2;
                sens = sens - sens2;
            end

            pres = (((d1 * sens) >>> 21) - off) >>> 15;

            r.temperature = clamp_to_int32(temp);
            r.pressure    = clamp_to_int32(pres);
            return r;
        endfunction

        function void note_sample(sample_t s);
            expected_results.push_back(compensate(s));
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (expected_results.size() == 0) begin
                $error("result beat arrived with no sample outstanding: temperature %0d, pressure %0d",
                       got.temperature, got.pressure);
                errors++;
                return;
            end
            want = expected_results.pop_front();
            if (got.temperature !== want.temperature) begin
                $error("temperature: expected %0d, got %0d", want.temperature, got.temperature);
                errors++;
            end
            if (got.pressure !== want.pressure) begin
                $error("pressure: expected %0d, got %0d", want.pressure, got.pressure);
                errors++;
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  sample_valid;
    logic                  sample_stall;
    sample_t               sample;
    logic                  result_valid;
    logic                  result_stall;
    result_t               result;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    compensation_scoreboard comp;

    // Idle rates in percent for the sample side and the result side. They are
    // changed per phase so that some phases run with no idling at all.
    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    // Set by the stimulus to ask the result side for one long hold-off.
    bit hold_req = 1'b0;
    int hold_left = 0;
    int stall_left = 0;
    int cycle_count = 0;

    baro_pressure_temp_compensation_top DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #10 clk = ~clk;

    // Length of an idle stretch: mostly from a short range, one time in eight from a long one.
    // A rate of zero means no idling at all.
    function automatic int pick_idle(int pct);
        if ($urandom_range(0, 99) >= pct) begin
            return 0;
        end
        if ($urandom_range(0, 7) == 0) begin
            return $urandom_range(10, 40);
        end
        return $urandom_range(1, 3);
    endfunction

    // Coefficients are mostly random, with the two extremes mixed in often.
    function automatic logic [15:0] pick_coef();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) begin
            return 16'd0;
        end
        if (roll == 1) begin
            return COEF_MAX;
        end
        return 16'($urandom);
    endfunction

    // Result side. The stall is decided at the falling edge so that it is stable
    // at the rising edge where the monitor below samples it. A hold-off asked for
    // by the stimulus is counted down here, cycle by cycle, while the sample side
    // keeps offering beats; the pipeline then fills and must push back.
    always @(negedge clk) begin
        if (hold_req) begin
            hold_left = LONG_HOLD;
            hold_req = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            result_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            result_stall <= 1'b1;
        end else if ($urandom_range(0, 99) < rx_stall_pct) begin
            stall_left = pick_idle(100) - 1;
            result_stall <= 1'b1;
        end else begin
            result_stall <= 1'b0;
        end
    end

    // Every result beat that the block hands over is checked against the oldest
    // prediction.
    always @(posedge clk) begin
        if (rst_n && result_valid && !result_stall) begin
            comp.check_result(result);
        end
    end

    // Watchdog: a hang anywhere ends the run as a failure.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("baro_pressure_temp_compensation_top test failed");
        $finish;
    end

    // Offers one sample beat and holds it until the block takes it, then idles
    // for a random number of cycles. When no idle follows, valid simply stays
    // high and the next call replaces the payload at the next falling edge.
    task automatic send_sample(input logic [23:0] d1, input logic [23:0] d2);
        sample_t s;
        int gap;
        s.raw_pressure    = d1;
        s.raw_temperature = d2;
        @(negedge clk);
        sample       <= s;
        sample_valid <= 1'b1;
        @(posedge clk);
        while (sample_stall) begin
            @(posedge clk);
        end
        comp.note_sample(s);
        gap = pick_idle(tx_idle_pct);
        if (gap > 0) begin
            @(negedge clk);
            sample_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // Random samples. A good share keeps the temperature reading near the
    // reference point so that mild and cold temperatures show up, not only the
    // far ends that fully random readings give with random coefficients.
    task automatic send_random_sample();
        int mode;
        int d2i;
        logic [23:0] d1, d2;
        mode = $urandom_range(0, 3);
        d1 = 24'($urandom);
        d2 = 24'($urandom);
        case (mode)
            1: begin
                d2i = int'(comp.coefs.ref_temp) * 256
                      + int'($urandom_range(0, 2097152)) - 1048576;
                if (d2i < 0) begin
                    d2i = 0;
                end
                if (d2i > 16777215) begin
                    d2i = 16777215;
                end
                d2 = d2i[23:0];
            end
            2: d1 = $urandom_range(0, 1) ? RAW_MAX : 24'd0;
            3: d2 = $urandom_range(0, 1) ? RAW_MAX : 24'd0;
            default: ;
        endcase
        send_sample(d1, d2);
    endtask

    // Waits until every prediction has been matched and then lets the pipeline
    // run empty, so that a register write cannot land on a beat in flight.
    task automatic wait_idle();
        @(negedge clk);
        sample_valid <= 1'b0;
        while (comp.expected_results.size() != 0) begin
            @(posedge clk);
        end
        repeat (STAGES + 2) @(posedge clk);
    endtask

    // One register write per clock; write enable stays high across a burst.
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        comp.set_register(index, data);
    endtask

    task automatic end_writes();
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Loads all coefficients and the enable. A write to the unmapped index with
    // random data rides along every time and must change nothing.
    task automatic program_coefs(input logic [15:0] c1, input logic [15:0] c2,
                                 input logic [15:0] c3, input logic [15:0] c4,
                                 input logic [15:0] c5, input logic [15:0] c6,
                                 input logic [15:0] enable_word);
        cfg_write(REG_SENS_BASE, c1);
        cfg_write(REG_OFF_BASE, c2);
        cfg_write(REG_SENS_TEMPCO, c3);
        cfg_write(REG_OFF_TEMPCO, c4);
        cfg_write(REG_REF_TEMP, c5);
        cfg_write(REG_TEMP_SENS, c6);
        cfg_write(REG_SO_ENABLE, enable_word);
        cfg_write(REG_UNMAPPED, 16'($urandom));
        end_writes();
    endtask

    initial begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        sample_valid = 1'b0;
        sample       = '0;
        result_stall = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        comp         = new();

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // With every register at its reset value of zero.
        send_sample(RAW_MAX, RAW_MAX);
        send_sample(24'd0, 24'd0);

        // Typical calibration data with the low-temperature correction on.
        // The reference point C5*256 is 8566784, and with C6 = 28312 a delta of
        // -1037020 lands exactly on -15.00 C while one less falls just below it.
        wait_idle();
        program_coefs(16'd40127, 16'd36924, 16'd23317, 16'd23282,
                      16'd33464, 16'd28312, 16'd1);
        send_sample(24'd9085466, 24'd8569150);
        send_sample(24'd0, 24'd0);
        send_sample(RAW_MAX, 24'd0);
        send_sample(RAW_MAX, RAW_MAX);
        send_sample(24'd0, RAW_MAX);
        // Zero delta, then a delta of -1 which gives 19.99 C, just cold enough.
        send_sample(24'd8000000, 24'd8566784);
        send_sample(24'd8000000, 24'd8566783);
        // Moderately cold, then either side of the very-cold threshold.
        send_sample(24'd9085466, 24'd8066784);
        send_sample(24'd9085466, 24'd7529764);
        send_sample(24'd9085466, 24'd7529763);

        // Correction off; the enable write carries ones above bit 0 that must
        // be dropped, leaving the enable clear.
        wait_idle();
        cfg_write(REG_SO_ENABLE, 16'hFFFE);
        end_writes();
        send_sample(24'd9085466, 24'd0);
        send_sample(RAW_MAX, 24'd7529763);

        // All coefficients at their maximum, enable set through a full word.
        wait_idle();
        program_coefs(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
        send_sample(RAW_MAX, 24'd0);
        send_sample(RAW_MAX, RAW_MAX);
        send_sample(24'd0, 24'd0);
        send_sample(RAW_MAX, 24'hFF_FF00);

        // All coefficients written back to zero with the correction on.
        wait_idle();
        program_coefs(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd1);
        send_sample(RAW_MAX, 24'd0);
        send_sample(RAW_MAX, RAW_MAX);

        // Random phases, each with fresh coefficients. The idle pattern cycles
        // through none, sample side only, result side only and both. The first
        // phase runs back to back and starts with the long result hold-off.
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            wait_idle();
            program_coefs(pick_coef(), pick_coef(), pick_coef(),
                          pick_coef(), pick_coef(), pick_coef(), 16'($urandom));
            tx_idle_pct  = (phase % 2 == 1) ? 30 : 0;
            rx_stall_pct = (phase % 4 >= 2) ? 30 : 0;
            if (phase == 0) begin
                hold_req = 1'b1;
            end
            repeat (ITEMS_PER_PHASE) send_random_sample();
        end

        wait_idle();
        if (comp.errors == 0) begin
            $display("baro_pressure_temp_compensation_top test passed");
        end else begin
            $display("baro_pressure_temp_compensation_top test failed");
        end
        $finish;
    end

endmodule
